// File: hw/rtl/quadratic_biquadratic_root_solver_assert.svh
// Assertion macros shared by the root solver RTL.
// Needs clk and rst_n in the scope of each use; define NO_ASSERTIONS to drop them.
`ifndef QUADRATIC_BIQUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_BIQUADRATIC_ROOT_SOLVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define QBRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication
`define QBRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define QBRS_ASSERT_IMPL(lbl, ante, cons)
`define QBRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/qbrs_pkg.sv
// Shared constants of the root solver: result status and root count codes, queue depth.
// No dependencies.
`timescale 1ns / 1ps
package qbrs_pkg;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOROOT = 2'd1;
  localparam logic [1:0] ST_AZERO  = 2'd2;

  // root count codes
  localparam logic [2:0] CNT_NONE = 3'd0;
  localparam logic [2:0] CNT_PAIR = 3'd2;
  localparam logic [2:0] CNT_QUAD = 3'd4;

  // entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

endpackage

// File: hw/rtl/qbrs_front.sv
// Front end of the root solver: input register, sign/magnitude split and a-is-zero check.
// Standalone; feeds qbrs_fifo.
`timescale 1ns / 1ps
module qbrs_front #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [W-1:0]         in_coef_a,
  input  logic [W-1:0]         in_coef_b,
  input  logic [W-1:0]         in_coef_c,
  input  logic                 in_mode,
  output logic                 f_vld,
  input  logic                 f_rdy,
  output logic [3*W+4:0]       f_item
);

  // layout shared with qbrs_back
  typedef struct packed {
    logic         azero;
    logic         mode;
    logic         an;
    logic         bn;
    logic         cn;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
  } item_t;

  logic  fv_r;
  item_t fitem_r;
  item_t fitem_nxt;
  logic  take;

  assign in_ready = !fv_r || f_rdy;
  assign take     = in_valid && in_ready;

  // split into sign and magnitude, flag a zero
  always_comb begin
    fitem_nxt.azero = (in_coef_a == '0);
    fitem_nxt.mode  = in_mode;
    fitem_nxt.an    = in_coef_a[W-1];
    fitem_nxt.bn    = in_coef_b[W-1];
    fitem_nxt.cn    = in_coef_c[W-1];
    fitem_nxt.am    = in_coef_a[W-1] ? ('0 - in_coef_a) : in_coef_a;
    fitem_nxt.bm    = in_coef_b[W-1] ? ('0 - in_coef_b) : in_coef_b;
    fitem_nxt.cm    = in_coef_c[W-1] ? ('0 - in_coef_c) : in_coef_c;
  end

  // hold the item until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (take) begin
      fv_r <= 1'b1;
    end else if (f_rdy) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fitem_r <= fitem_nxt;
    end
  end

  assign f_vld  = fv_r;
  assign f_item = fitem_r;

endmodule

// File: hw/rtl/qbrs_fifo.sv
// Small register queue that decouples the front end from the arithmetic pipeline.
// Standalone; uses the assertion macro header.
`timescale 1ns / 1ps
`include "quadratic_biquadratic_root_solver_assert.svh"
module qbrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    rp_r;
  logic [AW:0]      cnt_r;
  logic             push;
  logic             pop;

  assign in_rdy   = (cnt_r != AW'(0) + (AW+1)'(DEPTH)) ;
  assign out_vld  = (cnt_r != '0);
  assign push     = in_vld && in_rdy;
  assign pop      = out_vld && out_rdy;
  assign out_data = mem_r[rp_r];

  // store an item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `QBRS_ASSERT_IMPL(a_fifo_bound, 1'b1, cnt_r <= (AW+1)'(DEPTH))
  `QBRS_ASSERT_NEXT(a_fifo_inc, push && !pop, cnt_r == $past(cnt_r) + 1'b1)
  `QBRS_ASSERT_NEXT(a_fifo_dec, pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

// File: hw/rtl/qbrs_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side channel carried along.
// Standalone; used by qbrs_back.
`timescale 1ns / 1ps
module qbrs_sqrt #(
  parameter int N      = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [2*N-1:0]    in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [N-1:0]      out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int REM_W = N + 3;

  logic              vld_r  [N];
  logic [REM_W-1:0]  rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [2*N-1:0]    rad_r  [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [N-1:0]      root_in;
    logic [2*N-1:0]    rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
    end

    // bring down two radicand bits and try the next root bit
    assign t       = {rem_in[REM_W-3:0], rad_in[2*N-1 -: 2]};
    assign trial   = REM_W'({root_in, 2'b01});
    assign ge      = (t >= trial);
    assign rem_nxt = ge ? (t - trial) : t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= {root_in[N-2:0], ge};
        rad_r[i]  <= {rad_in[2*N-3:0], 2'b00};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// File: hw/rtl/qbrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side channel carried along.
// Standalone; used by qbrs_back.
`timescale 1ns / 1ps
module qbrs_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    t;
    logic [DEN_W:0]    diff;
    logic [DEN_W-1:0]  rem_nxt;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign nq_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign nq_in   = nq_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    // shift in the next dividend bit, subtract where it fits
    assign t       = {rem_in, nq_in[NUM_W-1]};
    assign ge      = (t >= {1'b0, den_in});
    assign diff    = t - {1'b0, den_in};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        nq_r[i]   <= {nq_in[NUM_W-2:0], ge};
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign out_quo  = nq_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];

endmodule

// File: hw/rtl/qbrs_back.sv
// Arithmetic back end: discriminant, its root, the two divisions, saturation, the
// biquadratic roots and the output register. Uses qbrs_pkg, qbrs_sqrt, qbrs_div.
`timescale 1ns / 1ps
`include "quadratic_biquadratic_root_solver_assert.svh"
module qbrs_back
  import qbrs_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  output logic           q_rdy,
  input  logic [3*W+4:0] q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic [2:0]     out_root_count,
  output logic [W-1:0]   out_root_1,
  output logic [W-1:0]   out_root_2,
  output logic [W-1:0]   out_root_3,
  output logic [W-1:0]   out_root_4,
  output logic           out_saturated
);

  localparam int LO   = W / 2;
  localparam int HI   = W - LO;
  localparam int PW   = 2 * W;
  localparam int DW   = 2 * W + 1;
  localparam int SQ_N = W + F + 1;
  localparam int MW   = SQ_N + 1;
  localparam int R2_N = (W + F + 1) / 2;
  localparam int XW   = R2_N + W;
  localparam logic [W-1:0]  MAXP    = {1'b0, {(W-1){1'b1}}};
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W - 1);
  localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);

  typedef struct packed {
    logic         azero;
    logic         mode;
    logic         an;
    logic         bn;
    logic         cn;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
  } item_t;

  typedef struct packed {
    logic         azero;
    logic         mode;
    logic         an;
    logic         bn;
    logic         sdiff;
    logic [W-1:0] am;
    logic [W-1:0] bm;
  } m_side_t;

  typedef struct packed {
    logic         azero;
    logic         mode;
    logic         an;
    logic         bn;
    logic         dneg;
    logic [W-1:0] am;
    logic [W-1:0] bm;
  } sq_side_t;

  typedef struct packed {
    logic azero;
    logic mode;
    logic an;
    logic dneg;
    logic neg1;
  } dv_side_t;

  typedef struct packed {
    logic         azero;
    logic         mode;
    logic         dneg;
    logic         y1n;
    logic         c1;
    logic         y2n;
    logic [W-1:0] y1m;
    logic [W-1:0] y2m;
  } bq_side_t;

  // clip a quotient magnitude to the signed range; returns {clip, magnitude}
  function automatic logic [W:0] sat_mag(input logic [MW-1:0] qo, input logic neg);
    logic [MW-1:0] lim;
    logic          clip;
    lim  = neg ? LIM_NEG : LIM_POS;
    clip = (qo > lim);
    return {clip, clip ? lim[W-1:0] : qo[W-1:0]};
  endfunction

  item_t q_it;
  logic  adv;

  assign q_it  = q_item;
  assign adv   = !out_valid || out_ready;
  assign q_rdy = adv;

  // ---------------- partial products ----------------
  logic                m1_vld_r;
  logic [W+LO-1:0]     bb_lo_r, ac_lo_r;
  logic [W+HI-1:0]     bb_hi_r, ac_hi_r;
  m_side_t             m1_side_r;
  m_side_t             m1_side_nxt;

  always_comb begin
    m1_side_nxt.azero = q_it.azero;
    m1_side_nxt.mode  = q_it.mode;
    m1_side_nxt.an    = q_it.an;
    m1_side_nxt.bn    = q_it.bn;
    m1_side_nxt.sdiff = q_it.an ^ q_it.cn;
    m1_side_nxt.am    = q_it.am;
    m1_side_nxt.bm    = q_it.bm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb_lo_r   <= (W+LO)'(q_it.bm) * (W+LO)'(q_it.bm[LO-1:0]);
      bb_hi_r   <= (W+HI)'(q_it.bm) * (W+HI)'(q_it.bm[W-1:LO]);
      ac_lo_r   <= (W+LO)'(q_it.am) * (W+LO)'(q_it.cm[LO-1:0]);
      ac_hi_r   <= (W+HI)'(q_it.am) * (W+HI)'(q_it.cm[W-1:LO]);
      m1_side_r <= m1_side_nxt;
    end
  end

  // ---------------- combine partial products ----------------
  logic          m2_vld_r;
  logic [PW-1:0] bb_r, ac_r;
  m_side_t       m2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb_r      <= PW'(bb_lo_r) + (PW'(bb_hi_r) << LO);
      ac_r      <= PW'(ac_lo_r) + (PW'(ac_hi_r) << LO);
      m2_side_r <= m1_side_r;
    end
  end

  // ---------------- discriminant ----------------
  logic          m3_vld_r;
  logic [DW-1:0] d_r;
  sq_side_t      m3_side_r;
  sq_side_t      m3_side_nxt;
  logic [PW+1:0] dsum;

  always_comb begin
    dsum = m2_side_r.sdiff ? ({2'b00, bb_r} + {ac_r, 2'b00})
                           : ({2'b00, bb_r} - {ac_r, 2'b00});
    m3_side_nxt.azero = m2_side_r.azero;
    m3_side_nxt.mode  = m2_side_r.mode;
    m3_side_nxt.an    = m2_side_r.an;
    m3_side_nxt.bn    = m2_side_r.bn;
    m3_side_nxt.dneg  = !m2_side_r.sdiff && dsum[PW+1];
    m3_side_nxt.am    = m2_side_r.am;
    m3_side_nxt.bm    = m2_side_r.bm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (adv) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r       <= dsum[DW-1:0];
      m3_side_r <= m3_side_nxt;
    end
  end

  // ---------------- square root of the discriminant ----------------
  logic            sq_vld;
  logic [SQ_N-1:0] sq_root;
  sq_side_t        sq_side;

  qbrs_sqrt #(
    .N      (SQ_N),
    .SIDE_W ($bits(sq_side_t))
  ) u_dsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (m3_vld_r),
    .in_rad   ({1'b0, d_r, {(2*F){1'b0}}}),
    .in_side  (m3_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------- numerator sums ----------------
  logic          n1_vld_r;
  logic [MW-1:0] p_r;
  logic [MW:0]   q_r;
  sq_side_t      n1_side_r;
  logic [MW:0]   bmf_x, s_x, p_sum;

  assign bmf_x = (MW+1)'({sq_side.bm, {F{1'b0}}});
  assign s_x   = (MW+1)'(sq_root);
  assign p_sum = bmf_x + s_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r <= 1'b0;
    end else if (adv) begin
      n1_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r       <= p_sum[MW-1:0];
      q_r       <= bmf_x - s_x;
      n1_side_r <= sq_side;
    end
  end

  // ---------------- numerator magnitudes and signs ----------------
  logic          n2_vld_r;
  logic [MW-1:0] num1_r, num2_r;
  logic [W:0]    den_r;
  dv_side_t      n2_side_r;
  logic          n2_neg2_r;
  logic          qneg, qnz, pnz;
  logic [MW:0]   q_neg_val;
  logic [MW-1:0] qmag;
  dv_side_t      n2_side_nxt;

  always_comb begin
    qneg      = q_r[MW];
    qnz       = (q_r != '0);
    pnz       = (p_r != '0);
    q_neg_val = '0 - q_r;
    qmag      = qneg ? q_neg_val[MW-1:0] : q_r[MW-1:0];
    n2_side_nxt.azero = n1_side_r.azero;
    n2_side_nxt.mode  = n1_side_r.mode;
    n2_side_nxt.an    = n1_side_r.an;
    n2_side_nxt.dneg  = n1_side_r.dneg;
    n2_side_nxt.neg1  = n1_side_r.bn ? qneg : pnz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n2_vld_r <= 1'b0;
    end else if (adv) begin
      n2_vld_r <= n1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1_r    <= n1_side_r.bn ? qmag : p_r;
      num2_r    <= n1_side_r.bn ? p_r : qmag;
      den_r     <= {n1_side_r.am, 1'b0};
      n2_side_r <= n2_side_nxt;
      n2_neg2_r <= !n1_side_r.bn && !qneg && qnz;
    end
  end

  // ---------------- divide by 2a ----------------
  logic          dv_vld;
  logic [MW-1:0] quo1, quo2;
  dv_side_t      dv_side;
  logic          dv_neg2;

  qbrs_div #(
    .NUM_W  (MW),
    .DEN_W  (W + 1),
    .SIDE_W ($bits(dv_side_t))
  ) u_div1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (n2_vld_r),
    .in_num   (num1_r),
    .in_den   (den_r),
    .in_side  (n2_side_r),
    .out_vld  (dv_vld),
    .out_quo  (quo1),
    .out_side (dv_side)
  );

  qbrs_div #(
    .NUM_W  (MW),
    .DEN_W  (W + 1),
    .SIDE_W (1)
  ) u_div2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (n2_vld_r),
    .in_num   (num2_r),
    .in_den   (den_r),
    .in_side  (n2_neg2_r),
    .out_vld  (),
    .out_quo  (quo2),
    .out_side (dv_neg2)
  );

  // ---------------- sign and saturate the quadratic roots ----------------
  logic     st_vld_r;
  bq_side_t st_side_r;
  logic     st_c2_r;
  bq_side_t st_side_nxt;
  logic     y1n, y2n;
  logic [W:0] s1, s2;

  always_comb begin
    y1n = (dv_side.neg1 ^ dv_side.an) && (quo1 != '0);
    y2n = (dv_neg2 ^ dv_side.an) && (quo2 != '0);
    s1  = sat_mag(quo1, y1n);
    s2  = sat_mag(quo2, y2n);
    st_side_nxt.azero = dv_side.azero;
    st_side_nxt.mode  = dv_side.mode;
    st_side_nxt.dneg  = dv_side.dneg;
    st_side_nxt.y1n   = y1n;
    st_side_nxt.c1    = s1[W];
    st_side_nxt.y2n   = y2n;
    st_side_nxt.y1m   = s1[W-1:0];
    st_side_nxt.y2m   = s2[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else if (adv) begin
      st_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_side_r <= st_side_nxt;
      st_c2_r   <= s2[W];
    end
  end

  // ---------------- biquadratic square roots ----------------
  logic            f_vld;
  logic [R2_N-1:0] r1, r2;
  bq_side_t        fs;
  logic            fc2;

  qbrs_sqrt #(
    .N      (R2_N),
    .SIDE_W ($bits(bq_side_t))
  ) u_bsqrt1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (st_vld_r),
    .in_rad   ((2*R2_N)'({st_side_r.y1m, {F{1'b0}}})),
    .in_side  (st_side_r),
    .out_vld  (f_vld),
    .out_root (r1),
    .out_side (fs)
  );

  qbrs_sqrt #(
    .N      (R2_N),
    .SIDE_W (1)
  ) u_bsqrt2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (st_vld_r),
    .in_rad   ((2*R2_N)'({st_side_r.y2m, {F{1'b0}}})),
    .in_side  (st_c2_r),
    .out_vld  (),
    .out_root (r2),
    .out_side (fc2)
  );

  // ---------------- result assembly ----------------
  logic [XW-1:0] r1x, r2x;
  logic          rc1, rc2;
  logic [W-1:0]  rv1, rv2, y1e, y2e;
  logic [1:0]    status_nxt;
  logic [2:0]    count_nxt;
  logic [W-1:0]  root1_nxt, root2_nxt, root3_nxt, root4_nxt;
  logic          sat_nxt;

  always_comb begin
    r1x = XW'(r1);
    r2x = XW'(r2);
    rc1 = (r1x > XW'(MAXP));
    rc2 = (r2x > XW'(MAXP));
    rv1 = rc1 ? MAXP : r1x[W-1:0];
    rv2 = rc2 ? MAXP : r2x[W-1:0];
    y1e = fs.y1n ? ('0 - fs.y1m) : fs.y1m;
    y2e = fs.y2n ? ('0 - fs.y2m) : fs.y2m;
  end

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = CNT_NONE;
    root1_nxt  = '0;
    root2_nxt  = '0;
    root3_nxt  = '0;
    root4_nxt  = '0;
    sat_nxt    = 1'b0;
    priority if (fs.azero) begin
      status_nxt = ST_AZERO;
    end else if (fs.dneg) begin
      status_nxt = ST_NOROOT;
    end else if (!fs.mode) begin
      count_nxt = CNT_PAIR;
      root1_nxt = y1e;
      root2_nxt = y2e;
      sat_nxt   = fs.c1 || fc2;
    end else if (!fs.y1n && !fs.y2n) begin
      count_nxt = CNT_QUAD;
      root1_nxt = '0 - rv1;
      root2_nxt = rv1;
      root3_nxt = '0 - rv2;
      root4_nxt = rv2;
      sat_nxt   = rc1 || rc2 || fs.c1 || fc2;
    end else if (!fs.y1n) begin
      count_nxt = CNT_PAIR;
      root1_nxt = '0 - rv1;
      root2_nxt = rv1;
      sat_nxt   = rc1 || fs.c1;
    end else if (!fs.y2n) begin
      count_nxt = CNT_PAIR;
      root1_nxt = '0 - rv2;
      root2_nxt = rv2;
      sat_nxt   = rc2 || fc2;
    end else begin
      status_nxt = ST_NOROOT;
    end
  end

  // output register
  logic         out_valid_r;
  logic [1:0]   out_status_r;
  logic [2:0]   out_root_count_r;
  logic [W-1:0] out_root_1_r, out_root_2_r, out_root_3_r, out_root_4_r;
  logic         out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r     <= status_nxt;
      out_root_count_r <= count_nxt;
      out_root_1_r     <= root1_nxt;
      out_root_2_r     <= root2_nxt;
      out_root_3_r     <= root3_nxt;
      out_root_4_r     <= root4_nxt;
      out_saturated_r  <= sat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_root_count = out_root_count_r;
  assign out_root_1     = out_root_1_r;
  assign out_root_2     = out_root_2_r;
  assign out_root_3     = out_root_3_r;
  assign out_root_4     = out_root_4_r;
  assign out_saturated  = out_saturated_r;

  `QBRS_ASSERT_IMPL(a_azero_empty, out_valid_r && out_status_r == ST_AZERO,
                    out_root_count_r == CNT_NONE && !out_saturated_r)
  `QBRS_ASSERT_IMPL(a_ok_count, out_valid_r && out_status_r == ST_OK,
                    out_root_count_r == CNT_PAIR || out_root_count_r == CNT_QUAD)
  `QBRS_ASSERT_IMPL(a_quad_pairs, out_valid_r && out_root_count_r == CNT_QUAD,
                    out_root_1_r == W'('0 - out_root_2_r) && out_root_3_r == W'('0 - out_root_4_r))

endmodule

// File: hw/rtl/quadratic_biquadratic_root_solver.sv
// Real roots of a*x^2+b*x+c (mode 0) or a*x^4+b*x^2+c (mode 1), signed fixed point.
//
// Channels: in_valid/in_ready carry one coefficient set (a, b, c, mode); out_valid/
// out_ready carry one result (status, root count, four roots, saturation flag).
// An item is taken on a rising edge with valid and ready both high.
// Throughput: one item per cycle while out_ready stays high; the pipeline is fully
// stage-per-step, so every item is independent.
// Path to out_valid: front register, queue, partial products and their sum, the
// discriminant, its pipelined square root (one stage per root bit), the numerator
// sums and signs, the two restoring dividers (one stage per quotient bit), sign and
// saturation, the biquadratic square roots and the output register.
// Stall: the arithmetic pipeline holds while out_valid is high and out_ready low;
// the front register and 4-entry queue take items until full, then in_ready drops.
// Reset (rst_n low, synchronous) clears all valid bits; no item is in flight after it.
// Status 2 (a is zero) and status 1 (no real root) return all roots as zero.
// Uses qbrs_pkg, qbrs_front, qbrs_fifo, qbrs_back.
`timescale 1ns / 1ps
module quadratic_biquadratic_root_solver
  import qbrs_pkg::*;
#(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  input  logic                         in_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [2:0]                   out_root_count,
  output logic signed [COEF_WIDTH-1:0] out_root_1,
  output logic signed [COEF_WIDTH-1:0] out_root_2,
  output logic signed [COEF_WIDTH-1:0] out_root_3,
  output logic signed [COEF_WIDTH-1:0] out_root_4,
  output logic                         out_saturated
);

  localparam int ITEM_W = 3 * COEF_WIDTH + 5;

  logic              f_vld, f_rdy;
  logic [ITEM_W-1:0] f_item;
  logic              q_vld, q_rdy;
  logic [ITEM_W-1:0] q_item;

  // classify and register incoming coefficient sets
  qbrs_front #(
    .W (COEF_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_coef_a (in_coef_a),
    .in_coef_b (in_coef_b),
    .in_coef_c (in_coef_c),
    .in_mode   (in_mode),
    .f_vld     (f_vld),
    .f_rdy     (f_rdy),
    .f_item    (f_item)
  );

  // decouple front from back
  qbrs_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld),
    .in_rdy   (f_rdy),
    .in_data  (f_item),
    .out_vld  (q_vld),
    .out_rdy  (q_rdy),
    .out_data (q_item)
  );

  // arithmetic pipeline and output register
  qbrs_back #(
    .W (COEF_WIDTH),
    .F (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_vld          (q_vld),
    .q_rdy          (q_rdy),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_root_count (out_root_count),
    .out_root_1     (out_root_1),
    .out_root_2     (out_root_2),
    .out_root_3     (out_root_3),
    .out_root_4     (out_root_4),
    .out_saturated  (out_saturated)
  );

endmodule

// File: tb/sv/qbrs_checker.sv
// Result checker for the root solver: watches both channels, predicts each result.
// Depends on qbrs_pkg for the status and root count codes.
`timescale 1ns / 1ps
module qbrs_checker
  import qbrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_coef_c,
  input  logic               in_mode,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [2:0]         out_root_count,
  input  logic signed [31:0] out_root_1,
  input  logic signed [31:0] out_root_2,
  input  logic signed [31:0] out_root_3,
  input  logic signed [31:0] out_root_4,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 roots_pending,
  output int                 roots_seen,
  output int                 quad_seen,
  output int                 sat_seen
);

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         count;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] r3;
    logic signed [31:0] r4;
    logic               sat;
  } roots_t;

  roots_t expected_roots[$];

  // Integer square root, floor, of a value below 2^128
  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Clip to the signed 32-bit range and note any clipping
  function automatic logic signed [31:0] clip32(logic signed [127:0] v, inout bit hit);
    if (v > 128'sh7fff_ffff) begin
      hit = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -128'sh8000_0000) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fourth_root(logic signed [31:0] y, inout bit hit);
    logic [127:0] sq;
    sq = floor_sqrt({96'd0, y} << 16);
    return clip32($signed(sq), hit);
  endfunction

  function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c, logic biq);
    logic signed [127:0] sa, sb, sc, disc, s, y1, y2;
    logic signed [31:0]  q1, q2, p, q;
    bit sat, c1, c2;
    roots_t res;
    sa = a; sb = b; sc = c;
    res = '0;
    sat = 0; c1 = 0; c2 = 0;
    if (sa == 0) begin
      res.status = ST_AZERO;
      return res;
    end
    disc = sb * sb - 4 * sa * sc;
    if (disc < 0) begin
      res.status = ST_NOROOT;
      return res;
    end
    s  = $signed(floor_sqrt(disc << 32));
    y1 = (-(sb <<< 16) - s) / (2 * sa);
    y2 = (-(sb <<< 16) + s) / (2 * sa);
    if (!biq) begin
      res.status = ST_OK;
      res.count  = CNT_PAIR;
      res.r1 = clip32(y1, sat);
      res.r2 = clip32(y2, sat);
      res.sat = sat;
      return res;
    end
    q1 = clip32(y1, c1);
    q2 = clip32(y2, c2);
    res.status = ST_OK;
    if (q1 >= 0 && q2 >= 0) begin
      p = fourth_root(q1, sat);
      q = fourth_root(q2, sat);
      res.count = CNT_QUAD;
      res.r1 = -p; res.r2 = p; res.r3 = -q; res.r4 = q;
      res.sat = sat | c1 | c2;
    end else if (q1 >= 0 || q2 >= 0) begin
      p = fourth_root(q1 >= 0 ? q1 : q2, sat);
      res.count = CNT_PAIR;
      res.r1 = -p; res.r2 = p;
      res.sat = sat | (q1 >= 0 ? c1 : c2);
    end else begin
      res.status = ST_NOROOT;
    end
    return res;
  endfunction

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    roots_t want, got;
    if (!rst_n) begin
      fail_count    <= 0;
      roots_pending <= 0;
      roots_seen    <= 0;
      quad_seen     <= 0;
      sat_seen      <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_roots.push_back(solve_roots(in_coef_a, in_coef_b, in_coef_c, in_mode));
      if (out_valid && out_ready) begin
        got = '{out_status, out_root_count, out_root_1, out_root_2, out_root_3,
                out_root_4, out_saturated};
        roots_seen <= roots_seen + 1;
        if (out_root_count == CNT_QUAD) quad_seen <= quad_seen + 1;
        if (out_saturated) sat_seen <= sat_seen + 1;
        if (expected_roots.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want != got) begin
            $display("%0t: mismatch status exp %0d act %0d, count exp %0d act %0d",
                     $time, want.status, got.status, want.count, got.count);
            $display("  roots exp %h %h %h %h sat %0d", want.r1, want.r2, want.r3,
                     want.r4, want.sat);
            $display("  roots act %h %h %h %h sat %0d", got.r1, got.r2, got.r3,
                     got.r4, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      roots_pending <= expected_roots.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Top of the root solver testbench: clock, reset, coefficient stimulus and verdict.
// Depends on qbrs_pkg, the solver RTL and qbrs_checker.
`timescale 1ns / 1ps
module tb;
  import qbrs_pkg::*;

  localparam int RANDOM_ITEMS = 830;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [31:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic in_mode = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, out_saturated;
  logic [1:0] out_status;
  logic [2:0] out_root_count;
  logic signed [31:0] out_root_1, out_root_2, out_root_3, out_root_4;
  int fail_count, roots_pending, roots_seen, quad_seen, sat_seen;
  int cycles = 0;
  int stall_left = 0;
  bit steady = 0;

  always #1 clk = ~clk;

  quadratic_biquadratic_root_solver dut (.*);

  qbrs_checker chk (.*);

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: stall a random number of cycles after each accepted item
  always @(posedge clk) begin
    int next;
    next = stall_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      if (out_valid && out_ready) next = steady ? 0 : $urandom_range(0, 18);
      stall_left <= next;
      out_ready  <= (next == 0);
    end
  end

  // Present one coefficient set after a random gap, hold until accepted
  task automatic send_coefs(logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] c, logic m);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    in_mode   <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [31:0] small_coef();
    return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
  endfunction

  initial begin
    logic signed [31:0] a, b, c;
    int kind;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a zero, no real roots, double root, extremes, each biquadratic branch
    for (int m = 0; m < 2; m++) begin
      send_coefs(0, 32'sh0001_0000, 32'sh0001_0000, 1'(m));
      send_coefs(32'sh0001_0000, 0, 32'sh0001_0000, 1'(m));
      send_coefs(32'sh0001_0000, -32'sh0002_0000, 32'sh0001_0000, 1'(m));
      send_coefs(32'sh0001_0000, -32'sh0005_0000, 32'sh0004_0000, 1'(m));
      send_coefs(32'sh0001_0000, 32'sh0001_0000, -32'sh0006_0000, 1'(m));
      send_coefs(32'sh0001_0000, 32'sh0005_0000, 32'sh0004_0000, 1'(m));
      send_coefs(32'sh0001_0000, 0, 0, 1'(m));
      send_coefs(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'(m));
      send_coefs(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'(m));
      send_coefs(1, 32'sh7fff_ffff, 1, 1'(m));
      send_coefs(-1, 32'sh8000_0000, -1, 1'(m));
    end

    // Random: mostly coefficient sets with real roots, some raw noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 5);
      case (kind)
        0: begin
          a = $urandom; b = $urandom; c = $urandom;
        end
        1: begin
          a = small_coef(); b = small_coef(); c = small_coef();
        end
        2: begin
          // a and c of opposite signs always give two real roots
          a = small_coef(); c = small_coef();
          if ((a < 0) == (c < 0)) c = -c;
          b = $urandom;
        end
        3: begin
          // positive a, non-negative c, strongly negative b: two non-negative roots
          a = $urandom_range(1, 32'h0004_0000);
          c = $urandom_range(0, 32'h0004_0000);
          b = -$signed($urandom_range(32'h0008_0000, 32'h7fff_0000));
        end
        4: begin
          a = $signed($urandom_range(1, 255)) - 128; b = $urandom; c = $urandom;
          if (a == 0) a = 1;
        end
        default: begin
          a = 0; b = $urandom; c = $urandom;
          if ($urandom_range(0, 4) != 0) a = small_coef();
        end
      endcase
      send_coefs(a, b, c, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    steady = 0;

    while (roots_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d results, %0d with four roots, %0d saturated", roots_seen,
             quad_seen, sat_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/qbrs_pkg.sv
hw/rtl/qbrs_front.sv
hw/rtl/qbrs_fifo.sv
hw/rtl/qbrs_sqrt.sv
hw/rtl/qbrs_div.sv
hw/rtl/qbrs_back.sv
hw/rtl/quadratic_biquadratic_root_solver.sv
tb/sv/qbrs_checker.sv
tb/sv/tb.sv
